/* sv/hafe_pkg.sv */
// Package for the HDLC async frame encoder: config and queue entry types,
// escape and CRC constants, the CRC-16/X-25 byte update and the back-end phase.
// No dependencies.
`timescale 1ns / 1ps

package hafe_pkg;

  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  XOR_MASK  = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] REG_START_ENABLE = 2'd0;
  localparam logic [1:0] REG_START_FLAG   = 2'd1;
  localparam logic [1:0] REG_END_FLAG     = 2'd2;

  typedef struct packed {
    logic       start_enable;
    logic [7:0] start_flag;
    logic [7:0] end_flag;
  } cfg_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic        has_start;
    logic [7:0]  start_byte;
    logic [7:0]  data;
    logic        last;
    logic [15:0] fcs;
    logic [7:0]  end_byte;
  } entry_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_END
  } phase_t;

  // reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* sv/hafe_if.sv */
// Valid/ready channel interfaces for payload input and framed byte output.
// No dependencies.
`timescale 1ns / 1ps

interface hafe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       data_last;

  modport source (output valid, data_byte, data_last, input ready);
  modport sink   (input valid, data_byte, data_last, output ready);
endinterface

interface hafe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

/* sv/hafe_front.sv */
// Front end: accepts payload requests, keeps the running CRC and frame state,
// and builds one queue entry per byte. Depends on hafe_pkg and hafe_in_if.
`timescale 1ns / 1ps

module hafe_front
  import hafe_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  hafe_in_if.sink       in_ch,
  input  cfg_t          cfg,
  input  logic          push_ready,
  output logic          push_valid,
  output entry_t        push_entry
);

  logic [15:0] crc_r, crc_nxt;
  logic        open_r, open_nxt;
  logic [15:0] crc_upd;
  logic        accept;

  // take a request whenever the queue has room
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push_valid  = accept;

  // restart the CRC on a frame's first byte
  assign crc_upd = crc_byte(open_r ? crc_r : CRC_INIT, in_ch.data_byte);

  // classify the byte into a queue entry
  always_comb begin
    push_entry.has_start  = !open_r && cfg.start_enable;
    push_entry.start_byte = cfg.start_flag;
    push_entry.data       = in_ch.data_byte;
    push_entry.last       = in_ch.data_last;
    push_entry.fcs        = ~crc_upd;
    push_entry.end_byte   = cfg.end_flag;
  end

  // advance the frame state
  always_comb begin
    crc_nxt  = crc_r;
    open_nxt = open_r;
    if (accept) begin
      if (in_ch.data_last) begin
        crc_nxt  = CRC_INIT;
        open_nxt = 1'b0;
      end else begin
        crc_nxt  = crc_upd;
        open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      open_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

/* sv/hafe_queue.sv */
// Short register queue of classified requests between front and back end.
// Depends on hafe_pkg.
`timescale 1ns / 1ps

module hafe_queue
  import hafe_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   push_ready,
  output logic   head_valid,
  output entry_t head_entry,
  input  logic   pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store payload, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* sv/hafe_back.sv */
// Back end: walks each queue entry through its start flag if any, escaped data
// and, on a last entry, escaped FCS and end flag, one byte per cycle unless
// out_ch stalls, into the output register. Depends on hafe_pkg and hafe_out_if.
`timescale 1ns / 1ps

module hafe_back
  import hafe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  entry_t    head_entry,
  output logic      pop,
  hafe_out_if.source out_ch
);

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  phase_t      eff_phase;
  logic [7:0]  cur_byte;
  logic        escapable;
  logic        need_esc;
  logic        load;

  // skip the start phase when the entry carries no start flag
  assign eff_phase = (phase_r == PH_START && !head_entry.has_start) ? PH_DATA : phase_r;
  assign load      = head_valid && (!out_valid_r || out_ch.ready);

  // pick the byte of the current phase
  always_comb begin
    case (eff_phase)
      PH_START:  cur_byte = head_entry.start_byte;
      PH_DATA:   cur_byte = head_entry.data;
      PH_FCS_LO: cur_byte = head_entry.fcs[7:0];
      PH_FCS_HI: cur_byte = head_entry.fcs[15:8];
      PH_END:    cur_byte = head_entry.end_byte;
      default:   cur_byte = head_entry.data;
    endcase
  end

  assign escapable = (eff_phase == PH_DATA) || (eff_phase == PH_FCS_LO) ||
                     (eff_phase == PH_FCS_HI);
  assign need_esc  = escapable && !esc_r && (cur_byte inside {ESC_BYTE, FLAG_BYTE});

  // next phase and escape state
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    pop       = 1'b0;
    if (load) begin
      if (need_esc) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt = 1'b0;
        case (eff_phase)
          PH_START:  phase_nxt = PH_DATA;
          PH_DATA: begin
            if (head_entry.last) begin
              phase_nxt = PH_FCS_LO;
            end else begin
              phase_nxt = PH_START;
              pop       = 1'b1;
            end
          end
          PH_FCS_LO: phase_nxt = PH_FCS_HI;
          PH_FCS_HI: phase_nxt = PH_END;
          PH_END: begin
            phase_nxt = PH_START;
            pop       = 1'b1;
          end
          default:   phase_nxt = PH_START;
        endcase
      end
    end
  end

  // output register contents
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = (eff_phase == PH_END);
      if (esc_r) begin
        out_byte_nxt = cur_byte ^ XOR_MASK;
      end else if (need_esc) begin
        out_byte_nxt = ESC_BYTE;
      end else begin
        out_byte_nxt = cur_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

endmodule

/* sv/hdlc_async_frame_encoder_unit.sv */
// HDLC async frame encoder with CRC-16/X-25 FCS. Payload bytes enter one per
// request on in_ch with a last-byte marker; framed bytes leave on out_ch, the end
// flag marked last. A front end accepts a byte and updates the CRC; a back-end
// sequencer emits one output byte per cycle while out_ch is not stalled, so a
// payload byte becomes one output byte, or two when it is 0x7D or 0x7E, plus the
// start flag, when enabled, on a frame's first byte and two to four FCS bytes and
// the end flag on its last. A queue of QDEPTH entries lets the input keep flowing
// while the output stalls, until the queue is full. Configuration (start_enable,
// start_flag, end_flag) is written on cfg_*; an unknown index is ignored.
// Depends on hafe_pkg, hafe_if, hafe_front, hafe_queue and hafe_back.
`timescale 1ns / 1ps

module hdlc_async_frame_encoder_unit
  import hafe_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  hafe_in_if.sink     in_ch,
  hafe_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t   cfg_r, cfg_nxt;
  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   head_valid;
  entry_t head_entry;
  logic   pop;

  // decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_START_ENABLE: cfg_nxt.start_enable = cfg_data[0];
        REG_START_FLAG:   cfg_nxt.start_flag   = cfg_data;
        REG_END_FLAG:     cfg_nxt.end_flag     = cfg_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_enable <= 1'b1;
      cfg_r.start_flag   <= FLAG_BYTE;
      cfg_r.end_flag     <= FLAG_BYTE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hafe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  hafe_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  hafe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

/* sim/tb.sv */
// Self-checking bench for hdlc_async_frame_encoder_unit: drives payload requests,
// predicts the framed, escaped byte stream with its CRC-16/X-25 FCS and checks it.
// Depends on hafe_pkg, hafe_if and the encoder RTL.
`timescale 1ns / 1ps

module tb;
  import hafe_pkg::*;

  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         IDLE_PCT   = 18;

  typedef struct packed {
    logic [7:0] val;
    logic       eof;
  } byte_rec_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  hafe_in_if  in_ch ();
  hafe_out_if out_ch ();

  hdlc_async_frame_encoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  byte_rec_t   payload_q[$];
  byte_rec_t   wire_q[$];
  byte_rec_t   got;
  byte_rec_t   want;
  cfg_t        cfg_now;
  logic [15:0] crc_run;
  logic        in_frame;
  logic        calm;
  int          err_cnt;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // known levels before the first edge
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.data_last = 1'b0;
    out_ch.ready    = 1'b0;
  end

  // reflected CRC-16 over one byte, polynomial 0x8408
  function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) begin
      if (r[0]) r = {1'b0, r[15:1]} ^ CRC_POLY;
      else      r = {1'b0, r[15:1]};
    end
    return r;
  endfunction

  task automatic push_wire(input logic [7:0] b, input logic eof);
    byte_rec_t rec;
    rec.val = b;
    rec.eof = eof;
    wire_q.push_back(rec);
  endtask

  // escape the two reserved bytes, pass any other through
  task automatic push_stuffed(input logic [7:0] b);
    if (b == ESC_BYTE || b == FLAG_BYTE) begin
      push_wire(ESC_BYTE, 1'b0);
      push_wire(b ^ XOR_MASK, 1'b0);
    end else begin
      push_wire(b, 1'b0);
    end
  endtask

  // work out the wire bytes that one accepted payload request causes
  task automatic encode_payload(input logic [7:0] b, input logic eof);
    logic [15:0] fcs;
    if (!in_frame) begin
      crc_run  = CRC_INIT;
      in_frame = 1'b1;
      if (cfg_now.start_enable) push_wire(cfg_now.start_flag, 1'b0);
    end
    push_stuffed(b);
    crc_run = fcs_update(crc_run, b);
    if (eof) begin
      fcs = crc_run ^ 16'hFFFF;
      push_stuffed(fcs[7:0]);
      push_stuffed(fcs[15:8]);
      push_wire(cfg_now.end_flag, 1'b1);
      crc_run  = CRC_INIT;
      in_frame = 1'b0;
    end
  endtask

  task automatic note_error(input byte_rec_t exp_rec, input byte_rec_t act, input bit orphan);
    err_cnt++;
    if (err_cnt <= 10) begin
      if (orphan)
        $display("tb: unexpected byte %02h last %0b at %0t", act.val, act.eof, $realtime);
      else
        $display("tb: mismatch exp byte %02h last %0b, got byte %02h last %0b at %0t",
                 exp_rec.val, exp_rec.eof, act.val, act.eof, $realtime);
    end
  endtask

  // driver: present queued payload requests, idle at random unless calm
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(payload_q.pop_front());
      if (!in_ch.valid || in_ch.ready) begin
        if (payload_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= payload_q[0].val;
          in_ch.data_last <= payload_q[0].eof;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on accepted requests first, then check the output byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) encode_payload(in_ch.data_byte, in_ch.data_last);
      if (out_ch.valid && out_ch.ready) begin
        got.val = out_ch.out_byte;
        got.eof = out_ch.out_last;
        if (wire_q.size() == 0) begin
          note_error(got, got, 1'b1);
        end else begin
          want = wire_q.pop_front();
          if (want.val !== got.val || want.eof !== got.eof) note_error(want, got, 1'b0);
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_ENABLE: cfg_now.start_enable = val[0];
      REG_START_FLAG:   cfg_now.start_flag   = val;
      REG_END_FLAG:     cfg_now.end_flag     = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic se, input logic [7:0] sf, input logic [7:0] ef);
    write_reg(REG_START_ENABLE, {7'd0, se});
    write_reg(REG_START_FLAG, sf);
    write_reg(REG_END_FLAG, ef);
  endtask

  task automatic queue_req(input logic [7:0] b, input logic eof);
    byte_rec_t rec;
    rec.val = b;
    rec.eof = eof;
    payload_q.push_back(rec);
  endtask

  // hold until every request is taken and every byte has come out
  task automatic wait_drained();
    do @(negedge clk);
    while (payload_q.size() != 0 || in_ch.valid || wire_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // lean towards the reserved bytes and their unescaped partners
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return ESC_BYTE;
      1:       return FLAG_BYTE;
      2:       return ESC_BYTE ^ XOR_MASK;
      3:       return FLAG_BYTE ^ XOR_MASK;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole frames, mostly short, now and then long
  task automatic queue_frames(input int n_req);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_req) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) queue_req(pick_byte(), k == len - 1);
      cnt += len;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_START_ENABLE;
    cfg_data  = 8'h00;
    calm      = 1'b0;
    err_cnt   = 0;
    crc_run   = CRC_INIT;
    in_frame  = 1'b0;
    cfg_now.start_enable = 1'b1;
    cfg_now.start_flag   = FLAG_BYTE;
    cfg_now.end_flag     = FLAG_BYTE;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte frames at the byte extremes and the reserved values
    queue_req(8'h00, 1'b1);
    queue_req(8'hFF, 1'b1);
    queue_req(ESC_BYTE, 1'b1);
    queue_req(FLAG_BYTE, 1'b1);
    // one longer frame mixing reserved bytes and their neighbours
    queue_req(FLAG_BYTE, 1'b0);
    queue_req(ESC_BYTE, 1'b0);
    queue_req(8'h5E, 1'b0);
    queue_req(8'h5D, 1'b0);
    queue_req(8'h01, 1'b0);
    queue_req(8'h80, 1'b1);
    wait_drained();

    // no start flag, low start value, high end value; unknown index ignored
    set_config(1'b0, 8'h00, 8'hFF);
    write_reg(REG_UNUSED, 8'hFF);
    queue_req(8'hAA, 1'b1);
    queue_req(8'h55, 1'b0);
    queue_req(FLAG_BYTE, 1'b0);
    wait_drained();

    // change registers with a frame still open: end flag applies at once
    write_reg(REG_END_FLAG, ESC_BYTE);
    write_reg(REG_START_ENABLE, 8'h01);
    queue_req(ESC_BYTE, 1'b0);
    queue_req(8'h33, 1'b1);
    queue_req(8'h42, 1'b1);
    wait_drained();

    // random frames under several settings, one phase without idling
    set_config(1'b0, 8'h00, 8'h00);
    queue_frames(70);
    wait_drained();

    set_config(1'b1, 8'hFF, 8'hFF);
    queue_frames(70);
    wait_drained();

    calm = 1'b1;
    set_config(1'b1, ESC_BYTE, FLAG_BYTE);
    queue_frames(70);
    wait_drained();
    calm = 1'b0;

    for (int p = 0; p < 2; p++) begin
      set_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      queue_frames(70);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
sv/hafe_pkg.sv
sv/hafe_if.sv
sv/hafe_front.sv
sv/hafe_queue.sv
sv/hafe_back.sv
sv/hdlc_async_frame_encoder_unit.sv
sim/tb.sv
